// ----- src/stereo_feedback_delay_macros.svh -----
// Assertion macros used by the stereo feedback delay top level.
// Checks compile out when SYNTH is defined.
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/sfd_pkg.sv -----
// Package for the stereo feedback delay: widths, types, register map,
// lane control struct and the saturation helper. No dependencies.
package sfd_pkg;

	localparam int DEPTH_BITS  = 16;
	localparam int DELAY_DEPTH = 1 << DEPTH_BITS;
	localparam int SAMPLE_BITS = 16;
	localparam int GAIN_BITS   = 16;
	localparam int FRAC_BITS   = 15;
	localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int SUM_BITS    = PROD_BITS + 1;
	localparam int HALF_LSB    = 1 << (FRAC_BITS - 1);
	localparam int PADDR_BITS  = 4;
	localparam int PDATA_BITS  = 32;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DEPTH_BITS-1:0]         addr_t;
	typedef logic [GAIN_BITS-1:0]          gain_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;

	typedef enum logic [1:0] {
		REG_DELAY = 2'd0,
		REG_DRY   = 2'd1,
		REG_WET   = 2'd2,
		REG_FB    = 2'd3
	} reg_idx_t;

	localparam gain_t DELAY_RST = GAIN_BITS'(0);
	localparam gain_t DRY_RST   = GAIN_BITS'(32768);
	localparam gain_t WET_RST   = GAIN_BITS'(16384);
	localparam gain_t FB_RST    = GAIN_BITS'(0);

	typedef struct packed {
		gain_t dry;
		gain_t wet;
		gain_t fb;
	} gains_t;

	typedef struct packed {
		logic  adv;
		logic  we;
		addr_t wr_s3;
		addr_t rd_s1;
		logic  hit_s3;
		logic  hit_wb;
		logic  rd_ok_s2;
	} lane_ctl_t;

	localparam sum_t SAT_HI = SUM_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam sum_t SAT_LO = ~SAT_HI;

	function automatic sample_t sat_sample(input sum_t v);
		sample_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[SAMPLE_BITS-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			r = v[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

endpackage

// ----- src/sfd_lane.sv -----
// One channel lane: delay memory, read forwarding, gain multipliers,
// rounding and saturation. Depends on sfd_pkg.
module sfd_lane import sfd_pkg::*; (
	input  logic      clk,
	input  lane_ctl_t ctl,
	input  gains_t    gains,
	input  sample_t   sample_in,
	output sample_t   sample_out
);

	sample_t mem [DELAY_DEPTH];

	sample_t in_s1, in_s2, in_s3;
	sample_t rdata_s2;
	sample_t wb_q;
	sample_t d_s2;
	prod_t   p_dry_s3, p_wet_s3, p_fb_s3;
	sum_t    out_sum_s3, fb_sum_s3, wr_sum_s3;
	sample_t wval_s3;

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			rdata_s2 <= mem[ctl.rd_s1];
			if (ctl.we) begin
				mem[ctl.wr_s3] <= wval_s3;
			end
		end
	end

	// newest pending write wins, then the one that raced the read
	always_comb begin
		if (ctl.hit_s3) begin
			d_s2 = wval_s3;
		end else if (ctl.hit_wb) begin
			d_s2 = wb_q;
		end else if (ctl.rd_ok_s2) begin
			d_s2 = rdata_s2;
		end else begin
			d_s2 = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			in_s1    <= sample_in;
			in_s2    <= in_s1;
			in_s3    <= in_s2;
			p_dry_s3 <= $signed({1'b0, gains.dry}) * in_s2;
			p_wet_s3 <= $signed({1'b0, gains.wet}) * d_s2;
			p_fb_s3  <= $signed({1'b0, gains.fb}) * d_s2;
			wb_q     <= wval_s3;
		end
	end

	always_comb begin
		out_sum_s3 = (SUM_BITS'(p_dry_s3) + SUM_BITS'(p_wet_s3) + $signed(SUM_BITS'(HALF_LSB)))
			>>> FRAC_BITS;
		fb_sum_s3  = (SUM_BITS'(p_fb_s3) + $signed(SUM_BITS'(HALF_LSB))) >>> FRAC_BITS;
		wr_sum_s3  = fb_sum_s3 + SUM_BITS'(in_s3);
		wval_s3    = sat_sample(wr_sum_s3);
		sample_out = sat_sample(out_sum_s3);
	end

endmodule

// ----- src/sfd_regs.sv -----
// APB-style configuration registers for the stereo feedback delay.
// Depends on sfd_pkg.
module sfd_regs import sfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready,
	output gain_t                 delay,
	output gains_t                gains
);

	gain_t    delay_q, dry_q, wet_q, fb_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[PADDR_BITS-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
			dry_q   <= DRY_RST;
			wet_q   <= WET_RST;
			fb_q    <= FB_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DELAY: delay_q <= pwdata[GAIN_BITS-1:0];
				REG_DRY:   dry_q   <= pwdata[GAIN_BITS-1:0];
				REG_WET:   wet_q   <= pwdata[GAIN_BITS-1:0];
				REG_FB:    fb_q    <= pwdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DELAY: prdata = PDATA_BITS'(delay_q);
			REG_DRY:   prdata = PDATA_BITS'(dry_q);
			REG_WET:   prdata = PDATA_BITS'(wet_q);
			REG_FB:    prdata = PDATA_BITS'(fb_q);
			default:   prdata = '0;
		endcase
	end

	assign delay     = delay_q;
	assign gains.dry = dry_q;
	assign gains.wet = wet_q;
	assign gains.fb  = fb_q;

endmodule

// ----- src/stereo_feedback_delay.sv -----
// Stereo feedback delay (echo): top level with pipeline control, forwarding
// compares and the output merge. Depends on sfd_pkg, sfd_lane, sfd_regs.
//
// Usage:
//   s_* stream takes one stereo frame per item, m_* stream returns one
//   processed frame per item, in order. APB port holds delay, dry, wet and
//   feedback gain at byte addresses 0x0, 0x4, 0x8, 0xC; write only while idle.
//   Items pass stages s1, s2, s3, then the output register driving m_tvalid.
//   Throughput: one item per cycle unless m_tready stalls; each lane memory
//   does one read and one write per cycle; short delays use both pending writes.
//   Reset clears registers, write index and the fill flag; memory is not
//   swept: entries not yet written since reset read as zero via the fill
//   flag, so items are taken right after reset.
//   A stalled m_tready freezes the whole pipeline and drops s_tready; an
//   item waiting in the output register never blocks the next accept once
//   m_tready is high.
module stereo_feedback_delay import sfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,  // left_in[15:0], right_in[31:16]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,  // left_out[15:0], right_out[31:16]
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0] prdata,
	output logic                  pready
);

	`include "stereo_feedback_delay_macros.svh"

	gain_t     delay;
	gains_t    gains;
	lane_ctl_t ctl;

	logic    adv, acc;
	addr_t   wr_q, rd_c;
	logic    filled_q, rd_ok_c;
	logic    v_s1, v_s2, v_s3;
	addr_t   rd_s1, rd_s2, wr_s1, wr_s2, wr_s3;
	logic    ok_s1, ok_s2;
	addr_t   wb_addr_q;
	logic    wb_v_q;
	logic    m_tvalid_q;
	sample_t left_s3, right_s3;
	sample_t left_q, right_q;

	sfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.delay   (delay),
		.gains   (gains)
	);

	assign adv      = !m_tvalid_q || m_tready;
	assign acc      = s_tvalid && adv;
	assign s_tready = adv;

	assign rd_c    = wr_q - delay[DEPTH_BITS-1:0];
	assign rd_ok_c = filled_q || (rd_c < wr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q       <= '0;
			filled_q   <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			wb_v_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc) begin
				wr_q <= wr_q + 1'b1;
				if (wr_q == '1) begin
					filled_q <= 1'b1;
				end
			end
			if (adv) begin
				v_s1       <= acc;
				v_s2       <= v_s1;
				v_s3       <= v_s2;
				wb_v_q     <= v_s3;
				m_tvalid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1     <= rd_c;
			wr_s1     <= wr_q;
			ok_s1     <= rd_ok_c;
			rd_s2     <= rd_s1;
			wr_s2     <= wr_s1;
			ok_s2     <= ok_s1;
			wr_s3     <= wr_s2;
			wb_addr_q <= wr_s3;
			left_q    <= left_s3;
			right_q   <= right_s3;
		end
	end

	always_comb begin
		ctl.adv      = adv;
		ctl.we       = v_s3;
		ctl.wr_s3    = wr_s3;
		ctl.rd_s1    = rd_s1;
		ctl.hit_s3   = v_s3 && (wr_s3 == rd_s2);
		ctl.hit_wb   = wb_v_q && (wb_addr_q == rd_s2);
		ctl.rd_ok_s2 = ok_s2;
	end

	sfd_lane u_left (
		.clk        (clk),
		.ctl        (ctl),
		.gains      (gains),
		.sample_in  (s_tdata[15:0]),
		.sample_out (left_s3)
	);

	sfd_lane u_right (
		.clk        (clk),
		.ctl        (ctl),
		.gains      (gains),
		.sample_in  (s_tdata[31:16]),
		.sample_out (right_s3)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {right_q, left_q};

	`ASSERT_IMP(a_single_fwd, clk, arst_n, 1'b1, !(ctl.hit_s3 && ctl.hit_wb))
	`ASSERT_IMP(a_fill_order, clk, arst_n, !filled_q && v_s3, wr_s3 < wr_q)
	`ASSERT_NXT(a_s3_to_out, clk, arst_n, v_s3 && adv, m_tvalid)
	`ASSERT_IMP(a_no_acc_blocked, clk, arst_n, m_tvalid && !m_tready, !acc)

endmodule

// ----- verif/tb_stereo_feedback_delay.sv -----
`timescale 1ns / 1ps
// Testbench for stereo_feedback_delay: streams stereo frames, sets delay and gains over APB
// and checks every output frame against the bench echo predictor or a fixed expected frame.
// Depends on sfd_pkg and the RTL top level only.
module tb_stereo_feedback_delay;
	import sfd_pkg::*;

	typedef struct packed {
		sample_t right;
		sample_t left;
	} stereo_t;

	typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		reg_idx_t  idx;
		gain_t     val;
		stereo_t   x;
		bit        chk;
		stereo_t   y;
	} stim_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic [31:0]           s_tdata  = '0;  // left_in[15:0], right_in[31:16]
	logic                  m_tready = 1'b0;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [PADDR_BITS-1:0] paddr    = '0;
	logic [PDATA_BITS-1:0] pwdata   = '0;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [31:0]           m_tdata;   // left_out[15:0], right_out[31:16]
	logic [PDATA_BITS-1:0] prdata;
	logic                  pready;

	stereo_feedback_delay dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// echo predictor state
	sample_t delay_mem [2][DELAY_DEPTH];
	addr_t   wr_ptr;
	gain_t   cfg_delay;
	gain_t   cfg_dry;
	gain_t   cfg_wet;
	gain_t   cfg_fb;

	stim_row_t   tx_q[$];
	stim_row_t   directed_q[$];
	stereo_t     echo_q[$];
	bit          idle_on = 1'b1;
	int unsigned stall_req = 0;
	int unsigned fail_count = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned reg_writes = 0;

	function automatic longint q15_round(longint acc);
		return (acc + HALF_LSB) >>> FRAC_BITS;
	endfunction

	function automatic sample_t clamp_sample(longint v);
		longint hi;
		hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
		if (v > hi) begin
			return sample_t'(hi);
		end else if (v < -hi - 1) begin
			return sample_t'(-hi - 1);
		end
		return sample_t'(v);
	endfunction

	function automatic sample_t echo_channel(int ch, sample_t x, addr_t rd);
		sample_t d;
		d = delay_mem[ch][rd];
		delay_mem[ch][wr_ptr] = clamp_sample(longint'(x) +
			q15_round(longint'(cfg_fb) * longint'(d)));
		return clamp_sample(q15_round(longint'(cfg_dry) * longint'(x) +
			longint'(cfg_wet) * longint'(d)));
	endfunction

	function automatic stereo_t echo_step(stereo_t x);
		stereo_t y;
		addr_t   rd;
		rd = wr_ptr - addr_t'(cfg_delay);
		y.left  = echo_channel(0, x.left, rd);
		y.right = echo_channel(1, x.right, rd);
		wr_ptr = wr_ptr + 1'b1;
		return y;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(15))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic gain_t pick_gain();
		case ($urandom_range(7))
			0: return '0;
			1: return gain_t'(32768);
			2: return '1;
			3: return gain_t'(1 << $urandom_range(15));
			default: return gain_t'($urandom_range(32768));
		endcase
	endfunction

	function automatic gain_t pick_delay();
		case ($urandom_range(5))
			0: return '0;
			1: return gain_t'($urandom_range(1, 3));
			2: return '1;
			3: return gain_t'($urandom_range(4, 64));
			default: return gain_t'($urandom_range(65535));
		endcase
	endfunction

	task automatic report_fail(string msg);
		if (fail_count < 10) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
		fail_count++;
	endtask

	task automatic add_frame(int l, int r);
		stim_row_t row;
		row.kind = ROW_FRAME;
		row.idx = REG_DELAY;
		row.val = '0;
		row.x.left = sample_t'(l);
		row.x.right = sample_t'(r);
		row.chk = 1'b0;
		row.y = '0;
		directed_q.push_back(row);
	endtask

	task automatic add_checked(int l, int r, int el, int er);
		add_frame(l, r);
		directed_q[$].chk = 1'b1;
		directed_q[$].y.left = sample_t'(el);
		directed_q[$].y.right = sample_t'(er);
	endtask

	task automatic add_cfg(reg_idx_t idx, gain_t val);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.val = val;
		row.x = '0;
		row.chk = 1'b0;
		row.y = '0;
		directed_q.push_back(row);
	endtask

	// starts and ends just after a rising edge
	task automatic drive_frames();
		stim_row_t row;
		stereo_t   y;
		while (tx_q.size() != 0) begin
			if (idle_on && $urandom_range(99) < 14) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end else begin
				row = tx_q[0];
				s_tvalid <= 1'b1;
				s_tdata <= row.x;
				@(posedge clk);
				while (!s_tready) @(posedge clk);
				void'(tx_q.pop_front());
				y = echo_step(row.x);
				echo_q.push_back(row.chk ? row.y : y);
				items_sent++;
			end
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (echo_q.size() != 0) @(posedge clk);
	endtask

	// write, then read back
	task automatic reg_write(reg_idx_t idx, gain_t val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= PDATA_BITS'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_DELAY: cfg_delay = val;
			REG_DRY:   cfg_dry = val;
			REG_WET:   cfg_wet = val;
			REG_FB:    cfg_fb = val;
		endcase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata[GAIN_BITS-1:0] !== val) begin
			report_fail($sformatf("readback of %s: expected %h, got %h",
				idx.name(), val, prdata[GAIN_BITS-1:0]));
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	task automatic run_phase(gain_t dly, gain_t dry, gain_t wet, gain_t fb, int n, int stall);
		stim_row_t row;
		wait_drain();
		reg_write(REG_DELAY, dly);
		reg_write(REG_DRY, dry);
		reg_write(REG_WET, wet);
		reg_write(REG_FB, fb);
		row.kind = ROW_FRAME;
		row.idx = REG_DELAY;
		row.val = '0;
		row.chk = 1'b0;
		row.y = '0;
		repeat (n) begin
			row.x.left = pick_sample();
			row.x.right = pick_sample();
			tx_q.push_back(row);
		end
		stall_req = stall;
		drive_frames();
	endtask

	always @(posedge clk) begin : rx_side
		stereo_t     got;
		stereo_t     want;
		int unsigned hold_left;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				if (echo_q.size() == 0) begin
					report_fail($sformatf("output frame %h with none pending", got));
				end else begin
					want = echo_q.pop_front();
					if (got.left !== want.left) begin
						report_fail($sformatf("out frame %0d left: expected %0d, got %0d",
							results_seen, want.left, got.left));
					end
					if (got.right !== want.right) begin
						report_fail($sformatf("out frame %0d right: expected %0d, got %0d",
							results_seen, want.right, got.right));
					end
				end
			end
			if (stall_req != 0) begin
				hold_left = stall_req;
				stall_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(99) < 14);
			end
		end else begin
			hold_left = 0;
		end
	end

	initial begin
		#(5_000_000);
		$display("timeout: %0d frames pending", echo_q.size());
		$display("FAILURE");
		$finish;
	end

	initial begin : main_seq
		stim_row_t row;
		for (int i = 0; i < DELAY_DEPTH; i++) begin
			delay_mem[0][i] = '0;
			delay_mem[1][i] = '0;
		end
		wr_ptr = '0;
		cfg_delay = DELAY_RST;
		cfg_dry = DRY_RST;
		cfg_wet = WET_RST;
		cfg_fb = FB_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, nothing written yet: output equals input
		add_checked(0, 0, 0, 0);
		add_checked(32767, -32768, 32767, -32768);
		add_checked(-32768, 32767, -32768, 32767);
		add_checked(1, -1, 1, -1);
		add_checked(-1, 1, -1, 1);
		add_checked(21845, -21846, 21845, -21846);
		add_cfg(REG_DELAY, 16'd3);
		add_frame(1000, -1000);
		add_frame(-20000, 20000);
		add_frame(32767, 32767);
		add_frame(-32768, -32768);
		add_cfg(REG_FB, 16'd32768);
		add_frame(12345, -12345);
		add_frame(32767, -32768);
		add_frame(-7, 7);
		add_cfg(REG_DELAY, 16'd1);
		add_frame(30000, -30000);
		add_frame(30000, -30000);
		add_frame(-1, 1);
		// gains above unity saturate
		add_cfg(REG_DRY, 16'hFFFF);
		add_cfg(REG_WET, 16'hFFFF);
		add_frame(32767, -32768);
		add_frame(-32768, 32767);
		add_cfg(REG_DRY, 16'd0);
		add_cfg(REG_WET, 16'd0);
		add_checked(32767, -32768, 0, 0);
		add_checked(-1, 1, 0, 0);
		add_cfg(REG_DELAY, 16'hFFFF);
		add_frame(5, -5);

		foreach (directed_q[i]) begin
			row = directed_q[i];
			if (row.kind == ROW_CFG) begin
				drive_frames();
				wait_drain();
				reg_write(row.idx, row.val);
			end else begin
				tx_q.push_back(row);
			end
		end
		drive_frames();

		for (int p = 0; p < 6; p++) begin
			run_phase(pick_delay(), pick_gain(), pick_gain(), pick_gain(), 150,
				(p == 2) ? 250 : 0);
		end

		// back to back, shortest delay, full feedback
		idle_on = 1'b0;
		run_phase(16'd1, 16'd32768, 16'd32768, 16'd32768, 300, 0);
		idle_on = 1'b1;

		// short delay with feedback up to unity, echoes build up
		run_phase(gain_t'($urandom_range(1, 64)), pick_gain(), pick_gain(),
			gain_t'($urandom_range(32768)), 150, 0);
		run_phase(16'd0, pick_gain(), pick_gain(), pick_gain(), 150, 0);
		run_phase(16'hFFFF, pick_gain(), pick_gain(), pick_gain(), 150, 0);
		run_phase(gain_t'($urandom_range(1000, 65535)), pick_gain(), pick_gain(),
			pick_gain(), 150, 0);

		wait_drain();
		repeat (8) @(posedge clk);
		$display("%0d frames in, %0d frames out, %0d register writes",
			items_sent, results_seen, reg_writes);
		$display("covered zero/short/max delays, gains to 0xFFFF, long output stall");
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- stereo_feedback_delay.f -----
+incdir+src
src/sfd_pkg.sv
src/sfd_lane.sv
src/sfd_regs.sv
src/stereo_feedback_delay.sv
verif/tb_stereo_feedback_delay.sv
